// ===== rtl/core/csmv_pkg.sv =====
package csmv_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned RND_W  = 48;
  localparam int unsigned SUM_W  = 49;
  localparam int unsigned ADDR_W = 4;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_NZ    = 2'd2;

  localparam logic [1:0] REG_DIRECTION = 2'd0;
  localparam logic [1:0] REG_ROWS      = 2'd1;
  localparam logic [1:0] REG_COLS      = 2'd2;

  localparam logic [LEN_W-1:0] ROWS_RESET = 11'd1024;
  localparam logic [LEN_W-1:0] COLS_RESET = 11'd1024;

  typedef struct packed {
    logic             direction;
    logic [LEN_W-1:0] rows_in_use;
    logic [LEN_W-1:0] cols_in_use;
  } cfg_t;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_WRITE,
    KIND_READ,
    KIND_NZ,
    KIND_ERR
  } kind_t;

  typedef struct packed {
    logic load;
    logic wr_elem;
    logic rd;
    logic mul;
    logic rnd;
    logic mac_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  out_free;
  } stat_t;

endpackage

// ===== rtl/core/csmv_regs.sv =====
module csmv_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [csmv_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output csmv_pkg::cfg_t                   cfg
);
  import csmv_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction   <= 1'b0;
      cfg_r.rows_in_use <= ROWS_RESET;
      cfg_r.cols_in_use <= COLS_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_DIRECTION: cfg_r.direction   <= pwdata[0];
        REG_ROWS:      cfg_r.rows_in_use <= pwdata[LEN_W-1:0];
        REG_COLS:      cfg_r.cols_in_use <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DIRECTION: prdata = {31'd0, cfg_r.direction};
      REG_ROWS:      prdata = {{(32-LEN_W){1'b0}}, cfg_r.rows_in_use};
      REG_COLS:      prdata = {{(32-LEN_W){1'b0}}, cfg_r.cols_in_use};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/csmv_ctrl.sv =====
module csmv_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  csmv_pkg::stat_t stat,
  output csmv_pkg::cmd_t  cmd
);
  import csmv_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ISSUE  = 6'b000010,
    S_FETCH  = 6'b000100,
    S_ROUND  = 6'b001000,
    S_MAC    = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        unique case (stat.kind)
          KIND_WRITE: begin
            cmd.wr_elem = 1'b1;
            state_nxt   = S_IDLE;
          end
          KIND_READ, KIND_NZ: begin
            cmd.rd    = 1'b1;
            state_nxt = S_FETCH;
          end
          KIND_ERR: state_nxt = S_RESULT;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_FETCH: begin
        if (stat.kind == KIND_READ) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.rnd   = 1'b1;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        cmd.mac_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/csmv_dp.sv =====
module csmv_dp #(
  parameter int unsigned MAX_ROWS = 1024,
  parameter int unsigned MAX_COLS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  csmv_pkg::cfg_t                        cfg,
  input  csmv_pkg::cmd_t                        cmd,
  output csmv_pkg::stat_t                       stat,
  input  logic [1:0]                            in_mode,
  input  logic                                  in_vector_pick,
  input  logic [csmv_pkg::IDX_W-1:0]            in_element_index,
  input  logic [csmv_pkg::IDX_W-1:0]            in_row_index,
  input  logic [csmv_pkg::IDX_W-1:0]            in_col_index,
  input  logic signed [csmv_pkg::DATA_W-1:0]    in_data_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_status,
  output logic signed [csmv_pkg::DATA_W-1:0]    out_read_value,
  output logic [csmv_pkg::IDX_W-1:0]            out_read_index
);
  import csmv_pkg::*;

  localparam int unsigned YAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned XAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [1:0]              mode_r;
  logic                    pick_r;
  logic [IDX_W-1:0]        eidx_r;
  logic [IDX_W-1:0]        row_r;
  logic [IDX_W-1:0]        col_r;
  logic signed [DATA_W-1:0] data_r;

  logic [DATA_W-1:0] x_mem [MAX_COLS];
  logic [DATA_W-1:0] y_mem [MAX_ROWS];
  logic [DATA_W-1:0] x_rd_r, y_rd_r;
  logic              x_we, y_we;
  logic [XAW-1:0]    x_waddr, x_raddr;
  logic [YAW-1:0]    y_waddr, y_raddr;
  logic [DATA_W-1:0] x_wdata, y_wdata;

  logic signed [DATA_W-1:0] opnd, acc;
  logic signed [DATA_W-1:0] acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [RND_W-1:0]  q_r;
  logic signed [SUM_W-1:0]  sum;
  logic [DATA_W-1:0]        mac_res;

  logic row_ok, col_ok, eidx_ok;
  kind_t kind;
  logic [IDX_W-1:0] bad_idx;

  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic                     out_status_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic [IDX_W-1:0]         out_index_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      pick_r <= in_vector_pick;
      eidx_r <= in_element_index;
      row_r  <= in_row_index;
      col_r  <= in_col_index;
      data_r <= in_data_value;
    end
  end

  assign row_ok  = (LEN_W'(row_r) < cfg.rows_in_use) && (32'(row_r) < MAX_ROWS);
  assign col_ok  = (LEN_W'(col_r) < cfg.cols_in_use) && (32'(col_r) < MAX_COLS);
  assign eidx_ok = pick_r ?
                   ((LEN_W'(eidx_r) < cfg.rows_in_use) && (32'(eidx_r) < MAX_ROWS)) :
                   ((LEN_W'(eidx_r) < cfg.cols_in_use) && (32'(eidx_r) < MAX_COLS));

  always_comb begin
    kind    = KIND_NONE;
    bad_idx = eidx_r;
    unique case (mode_r)
      MODE_WRITE: kind = eidx_ok ? KIND_WRITE : KIND_ERR;
      MODE_READ:  kind = eidx_ok ? KIND_READ : KIND_ERR;
      MODE_NZ: begin
        kind    = (row_ok && col_ok) ? KIND_NZ : KIND_ERR;
        bad_idx = row_ok ? col_r : row_r;
      end
      default: kind = KIND_NONE;
    endcase
  end

  // store ports
  always_comb begin
    x_we    = 1'b0;
    y_we    = 1'b0;
    x_waddr = XAW'(col_r);
    y_waddr = YAW'(row_r);
    x_wdata = mac_res;
    y_wdata = mac_res;
    x_raddr = XAW'(col_r);
    y_raddr = YAW'(row_r);
    if (mode_r != MODE_NZ) begin
      x_raddr = XAW'(eidx_r);
      y_raddr = YAW'(eidx_r);
    end
    if (cmd.wr_elem) begin
      x_we    = ~pick_r;
      y_we    = pick_r;
      x_waddr = XAW'(eidx_r);
      y_waddr = YAW'(eidx_r);
      x_wdata = data_r;
      y_wdata = data_r;
    end else if (cmd.mac_wr) begin
      x_we = cfg.direction;
      y_we = ~cfg.direction;
    end
  end

  always_ff @(posedge clk) begin
    if (x_we) x_mem[x_waddr] <= x_wdata;
    if (cmd.rd) x_rd_r <= x_mem[x_raddr];
  end

  always_ff @(posedge clk) begin
    if (y_we) y_mem[y_waddr] <= y_wdata;
    if (cmd.rd) y_rd_r <= y_mem[y_raddr];
  end

  // multiply, round, accumulate
  assign opnd = cfg.direction ? $signed(y_rd_r) : $signed(x_rd_r);
  assign acc  = cfg.direction ? $signed(x_rd_r) : $signed(y_rd_r);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(data_r) * PROD_W'(opnd);
      acc_r  <= acc;
    end
    if (cmd.rnd) begin
      q_r <= RND_W'((prod_r + 64'sd32768) >>> 16);
    end
  end

  assign sum = SUM_W'(acc_r) + SUM_W'(q_r);

  always_comb begin
    if (sum > 49'sd2147483647)       mac_res = 32'h7FFF_FFFF;
    else if (sum < -49'sd2147483648) mac_res = 32'h8000_0000;
    else                             mac_res = sum[DATA_W-1:0];
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= (kind == KIND_ERR);
      out_value_r  <= (kind == KIND_ERR) ? '0 :
                      (pick_r ? $signed(y_rd_r) : $signed(x_rd_r));
      out_index_r  <= bad_idx;
    end
  end

  assign stat.kind      = kind;
  assign stat.out_free  = ~out_valid_r | ~out_stall;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_value_r;
  assign out_read_index = out_index_r;

endmodule

// ===== rtl/core/csr_sparse_matvec_accumulate.sv =====
// Sparse matrix-vector multiply-accumulate over two on-chip vector stores x and y.
// Input channel (in_valid/in_stall): one beat per item; mode 0 writes a vector
// element, mode 1 reads one back, mode 2 applies one nonzero (row, col, value):
// y[row] += value*x[col] when direction is 0, x[col] += value*y[row] when 1.
// Output channel (out_valid/out_stall): one beat for each read and for each item
// dropped because an index is out of range (status 1, value 0, offending index).
// Configuration: APB registers direction (0x0), rows_in_use (0x4), cols_in_use
// (0x8); write them only while the block is idle.
// Items are processed one at a time by a controller stepping a shared datapath:
// a write is a store write, a read a store read and its output beat, a nonzero
// a store read, 32x32 multiply, rounding, saturating add and write-back, an error
// its output beat. The next item is taken once the controller is back in idle.
// A finished beat waits in the output register; while out_stall holds it, the
// next item is still accepted and only stalls when it has a result of its own.
// Reset clears the controller, the output valid and the registers
// (direction 0, lengths 1024); vector contents are undefined until written.
module csr_sparse_matvec_accumulate #(
  parameter int unsigned MAX_ROWS = 1024,
  parameter int unsigned MAX_COLS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_mode,
  input  logic                                  in_vector_pick,
  input  logic [csmv_pkg::IDX_W-1:0]            in_element_index,
  input  logic [csmv_pkg::IDX_W-1:0]            in_row_index,
  input  logic [csmv_pkg::IDX_W-1:0]            in_col_index,
  input  logic signed [csmv_pkg::DATA_W-1:0]    in_data_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_status,
  output logic signed [csmv_pkg::DATA_W-1:0]    out_read_value,
  output logic [csmv_pkg::IDX_W-1:0]            out_read_index,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [csmv_pkg::ADDR_W-1:0]           paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import csmv_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  csmv_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csmv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  csmv_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .stat             (stat),
    .in_mode          (in_mode),
    .in_vector_pick   (in_vector_pick),
    .in_element_index (in_element_index),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_data_value    (in_data_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_read_value   (out_read_value),
    .out_read_index   (out_read_index)
  );

endmodule
